### sv/bbfq_pkg.sv
// Shared types and constants for the bounded byte FIFO queue.
package bbfq_pkg;

    localparam int DEPTH = 128;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 8;
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [7:0]       FILL_BYTE      = 8'h30;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd100;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_PEEK  = 3'd1,
        CMD_POP   = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_FILL  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_in;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_out;
        logic [7:0] count;
        logic       empty_res;
    } out_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic fill;
    } cell_ctrl_t;

endpackage

### sv/bbfq_cell.sv
// One storage cell of the shift chain: holds one byte, loads, shifts or fills.
module bbfq_cell (
    input  logic                           clk,
    input  bbfq_pkg::cell_ctrl_t           ctl,
    input  logic [bbfq_pkg::CNT_W-1:0]     index,
    input  logic [bbfq_pkg::CNT_W-1:0]     count,
    input  logic [7:0]                     data_in,
    input  logic [7:0]                     next_byte,
    output logic [7:0]                     byte_q
);
    import bbfq_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.push && (index == count))
        begin
            byte_next = data_in;
        end
        else if (ctl.pop)
        begin
            // advance toward the front
            byte_next = next_byte;
        end
        else if (ctl.fill && (index < count))
        begin
            byte_next = FILL_BYTE;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

### sv/bounded_byte_fifo_queue.sv
// Top level of the bounded byte FIFO queue: control, cell chain and result register.
// Latency: the result of a transaction is registered and appears at the output in the cycle after acceptance.
// Throughput: one transaction per cycle for every command, fill included, while the output
// is not stalled, since each cell rewrites itself in parallel; pop shifts all cells together.
// Reset: count clears, capacity returns to 100, output empties; stored bytes are not cleared.
module bounded_byte_fifo_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bbfq_pkg::in_t       in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bbfq_pkg::out_t      out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import bbfq_pkg::*;

    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(DEPTH);

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    out_t             out_data_reg;
    out_t             result;

    logic             accept;
    cell_ctrl_t       cell_ctl;
    logic [LIM_W-1:0] cap_ext;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] count_ext;
    logic [7:0]       cell_q [DEPTH];

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign cap_ext   = LIM_W'(cap_reg);
    assign limit     = (cap_ext > DEPTH_LIM) ? DEPTH_LIM : cap_ext;
    assign count_ext = LIM_W'(count_reg);

    always_comb
    begin
        cell_ctl        = '0;
        count_next      = count_reg;
        result.status   = ST_OK;
        result.data_out = 8'h00;
        case (cmd_t'(in_data.command))
            CMD_PUSH:
            begin
                if (count_ext >= limit)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    cell_ctl.push = accept;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            CMD_PEEK, CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    result.status = ST_EMPTY;
                end
                else
                begin
                    result.data_out = cell_q[0];
                    if (cmd_t'(in_data.command) == CMD_POP)
                    begin
                        cell_ctl.pop = accept;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_FILL:
            begin
                cell_ctl.fill = accept;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result.count     = 8'(LIM_W'(count_next));
        result.empty_res = (count_next == '0);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] next_byte;
        if (i == DEPTH - 1)
        begin : g_last
            assign next_byte = 8'h00;
        end
        else
        begin : g_mid
            assign next_byte = cell_q[i+1];
        end

        bbfq_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .index     (CNT_W'(i)),
            .count     (count_reg),
            .data_in   (in_data.data_in),
            .next_byte (next_byte),
            .byte_q    (cell_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAPACITY_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds chain depth");

    a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cell_ctl.push, cell_ctl.pop, cell_ctl.fill}))
        else $error("more than one cell operation at once");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctl.push |=> count_reg == ($past(count_reg) + CNT_W'(1)))
        else $error("push did not grow count");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_data_reg.empty_res == (count_reg == '0))
        else $error("empty flag disagrees with count");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready)
        else $error("input stalled without output backpressure");
`endif

endmodule

### bench/bbfq_checker.sv
// Scoreboard for the bounded byte FIFO queue: watches all three channels and checks each result.
module bbfq_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  bbfq_pkg::in_t   in_data,
    input  logic            out_valid,
    input  logic            out_ready,
    input  bbfq_pkg::out_t  out_data,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [7:0]      cfg_data,
    output int              fail_count,
    output int              pending,
    output int              checked
);
    import bbfq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] byte_mem [DEPTH];
    int         head_ptr;
    int         tail_ptr;
    int         held;
    logic [7:0] capacity_reg;
    out_t       expected_results [$];
    int         mismatch_total = 0;
    int         result_total = 0;

    task automatic report(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    // Advance the queue model by one command and return the result it should produce.
    function automatic out_t apply_command(input in_t item);
        out_t res;
        int   limit;
        int   p;
        int   i;
        res = '0;
        res.status = ST_OK;
        limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        case (item.command)
            CMD_PUSH:
            begin
                if (held >= limit)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    byte_mem[tail_ptr] = item.data_in;
                    tail_ptr = (tail_ptr + 1) % DEPTH;
                    held++;
                end
            end
            CMD_PEEK, CMD_POP:
            begin
                if (held == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.data_out = byte_mem[head_ptr];
                    if (item.command == CMD_POP)
                    begin
                        head_ptr = (head_ptr + 1) % DEPTH;
                        held--;
                    end
                end
            end
            CMD_CLEAR:
            begin
                head_ptr = 0;
                tail_ptr = 0;
                held = 0;
            end
            CMD_FILL:
            begin
                p = head_ptr;
                for (i = 0; i < held; i++)
                begin
                    byte_mem[p] = FILL_BYTE;
                    p = (p + 1) % DEPTH;
                end
            end
            default:
            begin
            end
        endcase
        res.count = 8'(held);
        res.empty_res = (held == 0);
        return res;
    endfunction

    task automatic compare_result(input out_t got);
        out_t want;
        if (expected_results.size() == 0)
        begin
            report($sformatf("result %h arrived with nothing expected", got));
            return;
        end
        want = expected_results.pop_front();
        result_total++;
        if (got.status !== want.status)
            report($sformatf("status got %0d, want %0d", got.status, want.status));
        if (got.data_out !== want.data_out)
            report($sformatf("data_out got %h, want %h", got.data_out, want.data_out));
        if (got.count !== want.count)
            report($sformatf("count got %0d, want %0d", got.count, want.count));
        if (got.empty_res !== want.empty_res)
            report($sformatf("empty_res got %b, want %b", got.empty_res, want.empty_res));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr = 0;
            tail_ptr = 0;
            held = 0;
            capacity_reg = CAPACITY_RESET;
            expected_results.delete();
        end
        else
        begin
            // Retire the older result before queueing the new transaction.
            if (out_valid && out_ready)
                compare_result(out_data);
            if (cfg_valid && cfg_ready)
                capacity_reg = cfg_data;
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(in_data));
        end
        pending <= expected_results.size();
        fail_count <= mismatch_total;
        checked <= result_total;
    end

endmodule

### bench/bounded_byte_fifo_queue_tb.sv
// Stimulus, clock, reset and verdict for the bounded byte FIFO queue testbench.
module bounded_byte_fifo_queue_tb;
    import bbfq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STALL_LIMIT      = 2000;
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct;
    int rx_idle_pct;
    int commands_sent = 0;
    int quiet_cycles = 0;

    bounded_byte_fifo_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bbfq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // End the run if no transaction moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d results still due",
                         STALL_LIMIT, pending);
                $display("bounded_byte_fifo_queue_tb: FAIL");
                $finish;
            end
        end
    end

    // Leaves valid high after acceptance; the next call or a lowering step follows at the
    // next falling edge.
    task automatic send_item(input logic [2:0] command, input logic [7:0] value);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{command: command, data_in: value};
        do
            @(posedge clk);
        while (!in_ready);
        commands_sent++;
    endtask

    task automatic drain_queue();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [7:0] value);
        drain_queue();
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly pushes and pops with random bytes; fill, clear and spare codes mixed in.
    task automatic run_traffic(input int n, input int push_pct, input int clear_pct);
        int         roll;
        logic [2:0] command;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < push_pct)
                command = CMD_PUSH;
            else if (roll < push_pct + clear_pct)
                command = CMD_CLEAR;
            else if (roll >= 98)
                command = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
            else if (roll >= 94)
                command = CMD_FILL;
            else if (roll >= 86)
                command = CMD_PEEK;
            else
                command = CMD_POP;
            send_item(command, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        tx_idle_pct = 6;
        rx_idle_pct = 47;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty-queue reads and fill, byte extremes, fill over held bytes, spare codes.
        send_item(CMD_POP, 8'h11);
        send_item(CMD_PEEK, 8'h22);
        send_item(CMD_FILL, 8'h33);
        send_item(CMD_PUSH, 8'h00);
        send_item(CMD_PUSH, 8'hFF);
        send_item(CMD_PUSH, 8'h5A);
        send_item(CMD_PEEK, 8'h00);
        send_item(CMD_POP, 8'hFF);
        send_item(CMD_FILL, 8'h00);
        send_item(CMD_PEEK, 8'h00);
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            send_item(3'(c), 8'hFF);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_POP, 8'h00);
        send_item(CMD_PUSH, 8'hA5);

        // Zero capacity refuses every push, with bytes held and without.
        write_capacity(8'd0);
        send_item(CMD_PUSH, 8'h01);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_PUSH, 8'h02);
        write_capacity(8'd1);
        send_item(CMD_PUSH, 8'h03);
        send_item(CMD_PUSH, 8'h04);

        write_capacity(8'd4);
        run_traffic(120, 45, 2);
        // Capacity beyond the store depth: fill to the hard limit.
        write_capacity(8'd255);
        run_traffic(200, 85, 0);

        tx_idle_pct = 47;
        rx_idle_pct = 6;
        write_capacity(8'd1);
        run_traffic(130, 45, 2);
        write_capacity(8'd128);
        run_traffic(200, 80, 0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_capacity(8'd37);
        run_traffic(130, 55, 2);
        // Drop the capacity below the held count; held bytes must still pop out.
        write_capacity(8'd100);
        repeat (10) send_item(CMD_PUSH, 8'($urandom_range(255)));
        write_capacity(8'd3);
        run_traffic(50, 40, 0);

        drain_queue();
        repeat (5) @(posedge clk);

        $display("%0d commands sent and %0d results compared over capacities", commands_sent,
                 checked);
        $display("0, 1, 3, 4, 37, 100, 128 and 255 with three sender/receiver stall patterns");
        if (fail_count == 0)
            $display("bounded_byte_fifo_queue_tb: PASS");
        else
            $display("bounded_byte_fifo_queue_tb: FAIL");
        $finish;
    end

endmodule
